/* hdl/edfs_pkg.sv */
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared constants, command codes, state encoding and record types for the
// earliest-deadline-first periodic task scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

  // Number of task slots and the widths that follow from it.
  localparam int unsigned MaxSlots = 16;
  localparam int unsigned SlotIdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned SlotCntW = $clog2(MaxSlots + 1);

  // Field widths of the interface.
  localparam int unsigned CmdW     = 2;
  localparam int unsigned WorkW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned TaskNumW = 4;

  // Command codes.
  localparam logic [CmdW-1:0] CmdLoad    = 2'd0;
  localparam logic [CmdW-1:0] CmdTick    = 2'd1;
  localparam logic [CmdW-1:0] CmdRestart = 2'd2;

  // Sweep sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StSweep,
    StWrite
  } edfs_state_e;

  // Static slot record, written by a load command.
  typedef struct packed {
    logic [WorkW-1:0] job_len;
    logic [WorkW-1:0] period;
    logic [WorkW-1:0] dl_offset;
  } edfs_slot_t;

  // Run-time slot record, updated on every tick.
  typedef struct packed {
    logic [WorkW-1:0] work_left;
    logic [TimeW-1:0] next_rel;
    logic [TimeW-1:0] abs_dl;
  } edfs_run_t;

  // Command from the front end to the sweep engine.
  typedef struct packed {
    logic                tick;
    logic                restart;
    logic                load;
    logic [SlotIdxW-1:0] load_idx;
    edfs_slot_t          load_rec;
    logic [SlotCntW-1:0] n_slots;
  } edfs_cmd_t;

  // Result of one tick, handed to the output register.
  typedef struct packed {
    logic                valid;
    logic [TimeW-1:0]    tick_time;
    logic                busy;
    logic [TaskNumW-1:0] task_num;
  } edfs_res_t;

endpackage

/* hdl/edfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module edfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/edfs_sweep.sv */
// ----------------------------------------------------------------------------
// EDF sweep engine
// Holds the slot memories and time counter. On a tick it streams every
// enabled slot through a read-modify-write pass, releases due jobs, tracks
// the earliest deadline and finally charges one tick to the winner.
// ----------------------------------------------------------------------------
module edfs_sweep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edfs_pkg::edfs_cmd_t cmd_i,
  input  logic                out_free_i,
  output logic                idle_o,
  output edfs_pkg::edfs_res_t res_o
);

  import edfs_pkg::*;

  edfs_state_e         state_q, state_d;
  logic [SlotCntW-1:0] n_q, n_d;
  logic [SlotCntW-1:0] rd_idx_q, rd_idx_d;
  logic [SlotIdxW-1:0] ex_idx_q, ex_idx_d;
  logic                pend_q, pend_d;
  logic                found_q, found_d;
  logic [SlotIdxW-1:0] best_idx_q, best_idx_d;
  edfs_run_t           best_q, best_d;
  logic [TimeW-1:0]    now_q;
  logic [MaxSlots-1:0] vld_q;

  logic                issue;
  logic [SlotIdxW-1:0] run_raddr;
  logic                run_we;
  logic [SlotIdxW-1:0] run_waddr;
  edfs_run_t           run_wdata;
  edfs_run_t           run_raw;
  edfs_run_t           run_cur;
  edfs_run_t           run_upd;
  edfs_slot_t          slot_rd;
  logic                rel;
  logic                cand;
  logic                advance;

  // Static slot parameters, written by load commands.
  edfs_ram #(
    .Width ($bits(edfs_slot_t)),
    .Depth (MaxSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (cmd_i.load_idx),
    .wdata_i (cmd_i.load_rec),
    .raddr_i (run_raddr),
    .rdata_o (slot_rd)
  );

  // Run-time state of every slot.
  edfs_ram #(
    .Width ($bits(edfs_run_t)),
    .Depth (MaxSlots)
  ) u_run_ram (
    .clk_i   (clk_i),
    .we_i    (run_we),
    .waddr_i (run_waddr),
    .wdata_i (run_wdata),
    .raddr_i (run_raddr),
    .rdata_o (run_raw)
  );

  // An entry not written since reset or restart reads as all zero.
  assign run_cur = vld_q[ex_idx_q] ? run_raw : '0;

  // Release check and job reload for the slot in the execute stage.
  always_comb begin
    rel     = pend_q && (run_cur.next_rel == now_q);
    run_upd = run_cur;
    if (rel) begin
      run_upd.work_left = slot_rd.job_len;
      run_upd.next_rel  = run_cur.next_rel + TimeW'(slot_rd.period);
      run_upd.abs_dl    = now_q + TimeW'(slot_rd.dl_offset);
    end
    cand = pend_q && (run_upd.work_left != '0) &&
           (!found_q || (run_upd.abs_dl < best_q.abs_dl));
  end

  // Sequencer: next state, read issue, write-back and result.
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    rd_idx_d   = rd_idx_q;
    ex_idx_d   = ex_idx_q;
    pend_d     = 1'b0;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    issue      = 1'b0;
    run_raddr  = rd_idx_q[SlotIdxW-1:0];
    run_we     = 1'b0;
    run_waddr  = ex_idx_q;
    run_wdata  = run_upd;
    advance    = 1'b0;
    res_o      = '0;

    unique case (state_q)
      StIdle: begin
        if (cmd_i.tick) begin
          n_d      = cmd_i.n_slots;
          rd_idx_d = '0;
          found_d  = 1'b0;
          state_d  = StSweep;
        end
      end
      StSweep: begin
        // Issue the read of the next slot while the previous one executes.
        issue = (rd_idx_q < n_q);
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
          ex_idx_d = rd_idx_q[SlotIdxW-1:0];
        end
        if (rel) begin
          run_we = 1'b1;
        end
        if (cand) begin
          found_d    = 1'b1;
          best_idx_d = ex_idx_q;
          best_d     = run_upd;
        end
        if (!issue) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        // Charge the winner and hand the result over once the output is free.
        if (out_free_i) begin
          if (found_q) begin
            run_we              = 1'b1;
            run_waddr           = best_idx_q;
            run_wdata           = best_q;
            run_wdata.work_left = best_q.work_left - 1'b1;
          end
          res_o.valid     = 1'b1;
          res_o.tick_time = now_q;
          res_o.busy      = found_q;
          res_o.task_num  = found_q ? TaskNumW'(best_idx_q) : '0;
          advance         = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign idle_o = (state_q == StIdle);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      n_q      <= n_d;
    end
  end

  // Time counter and entry valid bits; restart clears both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
      vld_q <= '0;
    end else if (cmd_i.restart) begin
      now_q <= '0;
      vld_q <= '0;
    end else begin
      if (advance) begin
        now_q <= now_q + 1'b1;
      end
      if (run_we) begin
        vld_q[run_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ex_idx_q   <= ex_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  // The sequencer hands over a result only into a free output register.
  a_res_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> out_free_i)
    else $error("Result produced while the output register is occupied.");

  // A slot in execution only exists during the sweep.
  a_pend_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == StSweep))
    else $error("Slot in execution outside the sweep.");

  // The read pointer never passes the number of enabled slots.
  a_rd_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> (rd_idx_q <= n_q))
    else $error("Sweep read pointer beyond the enabled slots.");

  // Every result advances time by exactly one tick.
  a_time_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !cmd_i.restart) |=> (now_q == $past(now_q) + 1'b1))
    else $error("Time did not advance by one after a tick.");

endmodule

/* hdl/edf_periodic_task_scheduler.sv */
// ----------------------------------------------------------------------------
// EDF periodic task scheduler
// Top level: command handshake, task count register, output register and
// the sweep engine over the slot memories.
// ----------------------------------------------------------------------------
// Flow: a transferred tick sweeps the n enabled slots, then charges the
// winner and registers the result; the sweep issues one slot read per cycle.
// A new command is accepted only while idle, after the result is handed over.
// Reset: asynchronous, clears time and all run state; task count becomes 1.
// Slot parameters are undefined until loaded.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [edfs_pkg::CountW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [edfs_pkg::CmdW-1:0]      cmd_i,
  input  logic [3:0]                     task_index_i,
  input  logic [edfs_pkg::WorkW-1:0]     exec_time_i,
  input  logic [edfs_pkg::WorkW-1:0]     period_ticks_i,
  input  logic [edfs_pkg::WorkW-1:0]     relative_deadline_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [edfs_pkg::TimeW-1:0]     tick_time_o,
  output logic                           busy_res_o,
  output logic [edfs_pkg::TaskNumW-1:0]  task_number_o
);

  import edfs_pkg::*;

  logic [CountW-1:0]   task_count_q;
  logic [SlotCntW-1:0] n_slots;
  logic                accept;
  logic                idle;
  logic                out_free;
  edfs_cmd_t           cmd;
  edfs_res_t           res;
  logic                out_valid_q;
  logic [TimeW-1:0]    tick_time_q;
  logic                busy_q;
  logic [TaskNumW-1:0] task_num_q;

  // Task count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      task_count_q <= cfg_wdata_i;
    end
  end

  // Saturate the enabled slot count to the number of slots.
  assign n_slots = (32'(task_count_q) > MaxSlots) ? SlotCntW'(MaxSlots)
                                                  : SlotCntW'(task_count_q);

  // Input transfer and command decode.
  assign in_ready_o = idle;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd                    = '0;
    cmd.tick               = accept && (cmd_i == CmdTick);
    cmd.restart            = accept && (cmd_i == CmdRestart);
    cmd.load               = accept && (cmd_i == CmdLoad) &&
                             (32'(task_index_i) < MaxSlots);
    cmd.load_idx           = SlotIdxW'(task_index_i);
    cmd.load_rec.job_len   = exec_time_i;
    cmd.load_rec.period    = period_ticks_i;
    cmd.load_rec.dl_offset = relative_deadline_i;
    cmd.n_slots            = n_slots;
  end

  edfs_sweep u_sweep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .out_free_i (out_free),
    .idle_o     (idle),
    .res_o      (res)
  );

  // Output register; it frees up in the cycle its transfer completes.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      tick_time_q <= res.tick_time;
      busy_q      <= res.busy;
      task_num_q  <= res.task_num;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tick_time_o   = tick_time_q;
  assign busy_res_o    = busy_q;
  assign task_number_o = task_num_q;

endmodule
